// ===== hdl/fpis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpis_pkg
// Shared constants and codes for the fixed-point image scaler.
// ----------------------------------------------------------------------------
package fpis_pkg;

  // Frame store geometry: word address bits and the per-bank index bits.
  localparam int unsigned FRAME_AW    = 18;
  localparam int unsigned BANK_AW     = FRAME_AW - 1;

  // Screen size; SCR_W holds either dimension plus the source widths.
  localparam int unsigned SCREEN_COLS = 240;
  localparam int unsigned SCREEN_ROWS = 240;
  localparam int unsigned SCR_W       = 11;

  // 10.16 step ratio and bilinear weight widths.
  localparam int unsigned STEP_W      = 26;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned WT_W        = 2 * FRAC_W - 8 + 1;

  // Divider operand widths.
  localparam int unsigned DEN_W       = 10;

  // Configuration port.
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W    = 4'd0,
    REG_SRC_H    = 4'd1,
    REG_STRIDE   = 4'd2,
    REG_ORIGIN_X = 4'd3,
    REG_ORIGIN_Y = 4'd4,
    REG_DST_W    = 4'd5,
    REG_DST_H    = 4'd6,
    REG_MODE     = 4'd7
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_e;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_CROPPED = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ===== hdl/fpis_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpis_if
// Valid/ready channels of the image scaler: request, result and config write.
// ----------------------------------------------------------------------------
interface fpis_in_if import fpis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [FRAME_AW-1:0] store_address;
  logic [31:0]         store_pixel;
  logic [7:0]          out_row;
  logic [8:0]          out_col;

  modport source (output valid, opcode, store_address, store_pixel, out_row, out_col,
                  input ready);
  modport sink   (input valid, opcode, store_address, store_pixel, out_row, out_col,
                  output ready);
endinterface

interface fpis_out_if import fpis_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic [15:0] dest_index;
  logic [1:0]  status;

  modport source (output valid, out_pixel, dest_index, status, input ready);
  modport sink   (input valid, out_pixel, dest_index, status, output ready);
endinterface

interface fpis_cfg_if import fpis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/fixed_point_image_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_image_scaler
// Frame-store scaler: stores source pixels and returns nearest or bilinear
// output pixels with their screen word index.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          accepted when
//  cfg_i    in   index, data                                      valid & ready
//  in_i     in   opcode, store_address, store_pixel, out_row/col  valid & ready
//  out_o    out  out_pixel, dest_index, status                    valid & ready
//
//  One item enters per cycle while in_i.ready is high; a request passes
//  through six register stages (two multiply stages, address, banked store
//  read, weight products, channel sum into the output register).
//  After each write to a known register the step ratios and crop offset are
//  rebuilt on a shared one-bit-per-cycle divider, three divisions of 26 steps,
//  while in_i.ready stays low. Reset clears these to zero.
//  A stalled output only backs up as far as the first empty stage; the store
//  is four banks (top/bottom row copy, even/odd word) so all neighbors read
//  in the same cycle. Unwritten store words read as unknown data.
// ----------------------------------------------------------------------------
module fixed_point_image_scaler import fpis_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  fpis_cfg_if.sink     cfg_i,
  fpis_in_if.sink      in_i,
  fpis_out_if.source   out_o
);

  localparam int unsigned XPOS_W = 9 + STEP_W;
  localparam int unsigned YPOS_W = 8 + STEP_W;
  localparam int unsigned XI_W   = XPOS_W - FRAC_W;
  localparam int unsigned YI_W   = YPOS_W - FRAC_W;

  typedef enum logic [1:0] {DV_IDLE, DV_X, DV_Y, DV_C} dv_state_e;

  typedef struct packed {
    logic                req;
    logic [FRAME_AW-1:0] addr;
    logic [31:0]         pix;
    status_e             status;
    logic [XPOS_W-1:0]   xpos;
    logic [YPOS_W-1:0]   ypos;
    logic [15:0]         drow;
    logic [15:0]         dcols;
    logic [15:0]         dcol;
  } s1_t;

  typedef struct packed {
    logic                req;
    logic [FRAME_AW-1:0] addr;
    logic [31:0]         pix;
    status_e             status;
    logic [FRAME_AW-1:0] xoff;
    logic [FRAME_AW-1:0] yoff;
    logic                right;
    logic                down;
    logic [3:0][WT_W-1:0] wt;
    logic [15:0]         dest;
  } s2_t;

  typedef struct packed {
    logic                req;
    logic [FRAME_AW-1:0] addr;
    logic [31:0]         pix;
    status_e             status;
    logic [FRAME_AW-1:0] base;
    logic                right;
    logic                down;
    logic [3:0][WT_W-1:0] wt;
    logic [15:0]         dest;
  } s3_t;

  typedef struct packed {
    status_e             status;
    logic                tpar;
    logic                bpar;
    logic                right;
    logic                down;
    logic [3:0][WT_W-1:0] wt;
    logic [15:0]         dest;
  } s4_t;

  typedef struct packed {
    status_e              status;
    logic [31:0]          tl;
    logic [3:0][3:0][7:0] term;
    logic [15:0]          dest;
  } s5_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] pix;
    logic [15:0] dest;
  } s6_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [9:0] src_w_q, src_h_q, stride_q, dst_w_q;
  logic [8:0] ox_q, oy_q;
  logic [7:0] dst_h_q;
  mode_e      mode_q;
  logic       cfg_fire, cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  // Only known indexes rebuild the derived values; others are dropped.
  assign cfg_wr      = cfg_fire && (cfg_i.index <= REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= 10'd320;
      src_h_q  <= 10'd240;
      stride_q <= 10'd320;
      ox_q     <= '0;
      oy_q     <= '0;
      dst_w_q  <= 10'd240;
      dst_h_q  <= 8'd240;
      mode_q   <= MODE_BILINEAR;
    end else if (cfg_fire) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_SRC_W:    src_w_q  <= cfg_i.data[9:0];
        REG_SRC_H:    src_h_q  <= cfg_i.data[9:0];
        REG_STRIDE:   stride_q <= cfg_i.data[9:0];
        REG_ORIGIN_X: ox_q     <= cfg_i.data[8:0];
        REG_ORIGIN_Y: oy_q     <= cfg_i.data[8:0];
        REG_DST_W:    dst_w_q  <= cfg_i.data[9:0];
        REG_DST_H:    dst_h_q  <= cfg_i.data[7:0];
        REG_MODE:     mode_q   <= mode_e'(cfg_i.data[0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Derived values: x step, y step, crop offset, one division after another
  // --------------------------------------------------------------------------
  dv_state_e         dv_q;
  logic              issue_q, settle_q;
  logic [STEP_W-1:0] x_step_q, y_step_q;
  logic [9:0]        crop_q;
  logic [STEP_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0]  div_den;
  logic              div_done, dv_busy;
  logic [9:0]        xpad;
  logic [19:0]       xpad_prod;

  // Half the columns cut from a wide image, plus one.
  assign xpad = ({1'b0, dst_w_q} > SCR_W'(SCREEN_COLS))
              ? 10'(({1'b0, dst_w_q} - SCR_W'(SCREEN_COLS)) >> 1) + 10'd1 : '0;
  assign xpad_prod = xpad * src_w_q;
  assign dv_busy   = (dv_q != DV_IDLE);

  always_comb begin
    unique case (dv_q)
      DV_X: begin
        div_num = {src_w_q, FRAC_W'(0)};
        div_den = dst_w_q;
      end
      DV_Y: begin
        div_num = {src_h_q, FRAC_W'(0)};
        div_den = DEN_W'(dst_h_q);
      end
      DV_C: begin
        div_num = STEP_W'(xpad_prod);
        div_den = dst_w_q;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  fpis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (issue_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q     <= DV_IDLE;
      issue_q  <= 1'b0;
      settle_q <= 1'b0;
      x_step_q <= '0;
      y_step_q <= '0;
      crop_q   <= '0;
    end else begin
      settle_q <= dv_busy;
      issue_q  <= 1'b0;
      if (cfg_wr) begin
        dv_q    <= DV_X;
        issue_q <= 1'b1;
      end else begin
        unique case (dv_q)
          DV_IDLE: ;
          // Drop a finish left over from a division cut short by a new write.
          DV_X: if (div_done && !issue_q) begin
            x_step_q <= div_quo;
            dv_q     <= DV_Y;
            issue_q  <= 1'b1;
          end
          DV_Y: if (div_done) begin
            y_step_q <= div_quo;
            dv_q     <= DV_C;
            issue_q  <= 1'b1;
          end
          DV_C: if (div_done) begin
            crop_q <= div_quo[9:0];
            dv_q   <= DV_IDLE;
          end
          default: dv_q <= DV_IDLE;
        endcase
      end
    end
  end

  // Window origin plus crop offset, as a store word offset.
  logic [FRAME_AW-1:0] base_off_q;
  logic [18:0]         org_prod;

  assign org_prod = stride_q * oy_q;

  always_ff @(posedge clk_i) begin
    base_off_q <= FRAME_AW'(org_prod) + FRAME_AW'(ox_q) + FRAME_AW'(crop_q);
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage takes a new item when empty or draining
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic in_fire;

  assign rdy6 = !v6_q || out_o.ready;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // Hold input while the derived values rebuild and in the cycle after.
  assign in_i.ready = rdy1 && !dv_busy && !settle_q;
  assign in_fire    = in_i.valid && in_i.ready;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;

  // Stage 1: range checks, screen placement, source position products.
  logic [SCR_W-1:0] ypad;

  always_comb begin
    ypad = ({3'b0, dst_h_q} < SCR_W'(SCREEN_ROWS))
         ? (SCR_W'(SCREEN_ROWS) - {3'b0, dst_h_q}) >> 1 : '0;
    s1_d.req   = (in_i.opcode == OP_REQUEST);
    s1_d.addr  = in_i.store_address;
    s1_d.pix   = in_i.store_pixel;
    if (in_i.out_row >= dst_h_q || {1'b0, in_i.out_col} >= dst_w_q ||
        {3'b0, in_i.out_row} >= SCR_W'(SCREEN_ROWS)) begin
      s1_d.status = ST_OUTSIDE;
    end else if ({2'b0, in_i.out_col} >= SCR_W'(SCREEN_COLS)) begin
      s1_d.status = ST_CROPPED;
    end else begin
      s1_d.status = ST_WRITTEN;
    end
    s1_d.xpos  = XPOS_W'(in_i.out_col) * XPOS_W'(x_step_q);
    s1_d.ypos  = YPOS_W'(in_i.out_row) * YPOS_W'(y_step_q);
    s1_d.drow  = 16'(in_i.out_row) + 16'(ypad);
    s1_d.dcols = ({1'b0, dst_w_q} > SCR_W'(SCREEN_COLS)) ? 16'(SCREEN_COLS)
                                                         : 16'(dst_w_q);
    s1_d.dcol  = 16'(in_i.out_col);
  end

  // Stage 2: edge flags, row offset, bilinear weights, screen index.
  logic [XI_W-1:0]     xi;
  logic [YI_W-1:0]     yi;
  logic [FRAC_W-1:0]   xd, yd;
  logic [FRAC_W:0]     ixd, iyd;
  logic [YI_W+9:0]     yprod;
  logic [2*FRAC_W+1:0] p0, p1, p2, p3;
  logic [15:0]         dprod;

  always_comb begin
    xi    = s1_q.xpos[XPOS_W-1:FRAC_W];
    yi    = s1_q.ypos[YPOS_W-1:FRAC_W];
    xd    = s1_q.xpos[FRAC_W-1:0];
    yd    = s1_q.ypos[FRAC_W-1:0];
    ixd   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, xd};
    iyd   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, yd};
    yprod = yi * stride_q;
    p0    = ixd * iyd;
    p1    = {1'b0, xd} * iyd;
    p2    = {1'b0, yd} * ixd;
    p3    = {1'b0, yd} * {1'b0, xd};
    dprod = s1_q.drow * s1_q.dcols;
    s2_d.req    = s1_q.req;
    s2_d.addr   = s1_q.addr;
    s2_d.pix    = s1_q.pix;
    s2_d.status = s1_q.status;
    s2_d.xoff   = FRAME_AW'(xi);
    s2_d.yoff   = FRAME_AW'(yprod);
    s2_d.right  = (({1'b0, xi} + 1'b1) < (XI_W+1)'(src_w_q));
    s2_d.down   = (({1'b0, yi} + 1'b1) < (YI_W+1)'(src_h_q));
    s2_d.wt[0]  = p0[2*FRAC_W:8];
    s2_d.wt[1]  = p1[2*FRAC_W:8];
    s2_d.wt[2]  = p2[2*FRAC_W:8];
    s2_d.wt[3]  = p3[2*FRAC_W:8];
    s2_d.dest   = dprod + s1_q.dcol;
  end

  // Stage 3: top-left store address.
  always_comb begin
    s3_d.req    = s2_q.req;
    s3_d.addr   = s2_q.addr;
    s3_d.pix    = s2_q.pix;
    s3_d.status = s2_q.status;
    s3_d.base   = base_off_q + s2_q.yoff + s2_q.xoff;
    s3_d.right  = s2_q.right;
    s3_d.down   = s2_q.down;
    s3_d.wt     = s2_q.wt;
    s3_d.dest   = s2_q.dest;
  end

  // Stage 4: banked store. Writes and reads share this boundary so a request
  // always sees every write that came before it.
  logic [FRAME_AW-1:0] top_a, top_a1, bot_a, bot_a1;
  logic [BANK_AW-1:0]  te_idx, to_idx, be_idx, bo_idx, wr_idx;
  logic                rd_en, wr_en;
  logic [31:0]         te_q, to_q, be_q, bo_q;
  logic [31:0]         mem_te [2**BANK_AW];
  logic [31:0]         mem_to [2**BANK_AW];
  logic [31:0]         mem_be [2**BANK_AW];
  logic [31:0]         mem_bo [2**BANK_AW];

  assign top_a  = s3_q.base;
  assign top_a1 = top_a + 1'b1;
  assign bot_a  = s3_q.base + FRAME_AW'(stride_q);
  assign bot_a1 = bot_a + 1'b1;
  // Word pair (a, a+1): the even bank holds (a+1)>>1 or a>>1, the odd a>>1.
  assign te_idx = top_a1[FRAME_AW-1:1];
  assign to_idx = top_a[FRAME_AW-1:1];
  assign be_idx = bot_a1[FRAME_AW-1:1];
  assign bo_idx = bot_a[FRAME_AW-1:1];
  assign wr_idx = s3_q.addr[FRAME_AW-1:1];
  assign rd_en  = rdy4;
  assign wr_en  = rdy4 && v3_q && !s3_q.req;

  always_ff @(posedge clk_i) begin
    if (wr_en && !s3_q.addr[0]) mem_te[wr_idx] <= s3_q.pix;
    if (rd_en) te_q <= mem_te[te_idx];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && s3_q.addr[0]) mem_to[wr_idx] <= s3_q.pix;
    if (rd_en) to_q <= mem_to[to_idx];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !s3_q.addr[0]) mem_be[wr_idx] <= s3_q.pix;
    if (rd_en) be_q <= mem_be[be_idx];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && s3_q.addr[0]) mem_bo[wr_idx] <= s3_q.pix;
    if (rd_en) bo_q <= mem_bo[bo_idx];
  end

  always_comb begin
    s4_d.status = s3_q.status;
    s4_d.tpar   = top_a[0];
    s4_d.bpar   = bot_a[0];
    s4_d.right  = s3_q.right;
    s4_d.down   = s3_q.down;
    s4_d.wt     = s3_q.wt;
    s4_d.dest   = s3_q.dest;
  end

  // Stage 5: pick the four neighbors, scale each byte by its weight.
  logic [3:0][31:0]   nb;
  logic [31:0]        tl, tr_raw, bl_raw, br_raw;
  logic [WT_W+7:0]    prod;

  always_comb begin
    tl     = s4_q.tpar ? to_q : te_q;
    tr_raw = s4_q.tpar ? te_q : to_q;
    bl_raw = s4_q.bpar ? bo_q : be_q;
    br_raw = s4_q.bpar ? be_q : bo_q;
    // Neighbors past the window edge fall back to the top-left pixel.
    nb[0]  = tl;
    nb[1]  = s4_q.right ? tr_raw : tl;
    nb[2]  = s4_q.down ? bl_raw : tl;
    nb[3]  = (s4_q.right && s4_q.down) ? br_raw : tl;
    prod   = '0;
    s5_d.status = s4_q.status;
    s5_d.tl     = tl;
    s5_d.dest   = s4_q.dest;
    for (int ch = 0; ch < 4; ch++) begin
      for (int k = 0; k < 4; k++) begin
        prod = nb[k][8*ch +: 8] * s4_q.wt[k];
        s5_d.term[ch][k] = prod[31:24];
      end
    end
  end

  // Stage 6: sum per channel, select mode, zero rejected requests.
  logic [9:0]  csum;
  logic [31:0] blend;

  always_comb begin
    csum  = '0;
    blend = '0;
    for (int ch = 0; ch < 4; ch++) begin
      csum = 10'(s5_q.term[ch][0]) + 10'(s5_q.term[ch][1])
           + 10'(s5_q.term[ch][2]) + 10'(s5_q.term[ch][3]);
      blend[8*ch +: 8] = csum[7:0];
    end
    s6_d.status = s5_q.status;
    if (s5_q.status != ST_WRITTEN) begin
      s6_d.pix  = '0;
      s6_d.dest = '0;
    end else begin
      s6_d.pix  = (mode_q == MODE_BILINEAR) ? blend : s5_q.tl;
      s6_d.dest = s5_q.dest;
    end
  end

  // Valid bits; write items drop out once stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_fire;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q && s3_q.req;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
    if (rdy5) s5_q <= s5_d;
    if (rdy6) s6_q <= s6_d;
  end

  assign out_o.valid      = v6_q;
  assign out_o.out_pixel  = s6_q.pix;
  assign out_o.dest_index = s6_q.dest;
  assign out_o.status     = s6_q.status;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_item_while_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !dv_busy)
    else $error("item accepted while derived values rebuild");

  a_rebuild_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dv_busy) |-> $past(cfg_wr))
    else $error("derived rebuild started without a register write");

  a_div_done_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> dv_busy)
    else $error("divider finished outside the rebuild sequence");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && s6_q.status != ST_WRITTEN) |-> (s6_q.pix == '0 && s6_q.dest == '0))
    else $error("rejected request carries pixel or index");

endmodule
`default_nettype wire

// ===== hdl/fpis_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpis_div
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module fpis_div import fpis_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [STEP_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(STEP_W + 1);

  logic [STEP_W-1:0] num_q, num_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic              zero_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic              take;

  always_comb begin
    trial  = {rem_q, num_q[STEP_W-1]};
    take   = (trial >= {1'b0, den_q});
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[STEP_W-2:0], take};
      rem_d = take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEP_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q  <= den_i;
      zero_q <= (den_i == '0);
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : num_q;

endmodule
`default_nettype wire

// ===== dv/tb_fixed_point_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_image_scaler
// Self-checking bench for the frame-store image scaler. Source pixels are
// loaded on demand and output pixels are requested under many window and
// scale settings. Every result is checked against a bit-true prediction of
// nearest and bilinear scaling, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_fixed_point_image_scaler;
  import fpis_pkg::*;

  localparam int unsigned NUM_REGS  = 8;
  // Input items (loads and requests) spread over the random phases.
  localparam int unsigned REQ_ITEMS = 790;
  localparam int unsigned FLUSH_CYC = 20;
  localparam longint unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd13;
  localparam longint unsigned STORE_MASK = (64'd1 << FRAME_AW) - 1;

  typedef struct packed {
    logic [31:0] pixel;
    logic [15:0] index;
    status_e     status;
  } scaled_px_t;

  // Predicts each scaled pixel and checks results in order.
  class scaler_scoreboard;
    logic [31:0]     store [longint unsigned];
    longint unsigned regs [NUM_REGS];
    longint unsigned x_step, y_step, crop_offset;
    scaled_px_t      pending_px [$];
    int              errors;

    function new();
      regs[REG_SRC_W]    = 320;
      regs[REG_SRC_H]    = 240;
      regs[REG_STRIDE]   = 320;
      regs[REG_ORIGIN_X] = 0;
      regs[REG_ORIGIN_Y] = 0;
      regs[REG_DST_W]    = 240;
      regs[REG_DST_H]    = 240;
      regs[REG_MODE]     = 1;
      x_step = 0;
      y_step = 0;
      crop_offset = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      longint unsigned w1, h1, w2, h2, xpad;
      if (idx >= NUM_REGS) return;
      case (idx)
        REG_ORIGIN_X, REG_ORIGIN_Y: regs[idx] = data & 10'h1FF;
        REG_DST_H:                  regs[idx] = data & 10'hFF;
        REG_MODE:                   regs[idx] = data & 10'h1;
        default:                    regs[idx] = data;
      endcase
      // Rebuild step ratios and crop offset.
      w1 = regs[REG_SRC_W];
      h1 = regs[REG_SRC_H];
      w2 = regs[REG_DST_W];
      h2 = regs[REG_DST_H];
      xpad = (w2 > SCREEN_COLS) ? (w2 - SCREEN_COLS) / 2 + 1 : 0;
      x_step = (w2 != 0) ? ((w1 << 16) / w2) & 64'h3FFFFFF : 0;
      y_step = (h2 != 0) ? ((h1 << 16) / h2) & 64'h3FFFFFF : 0;
      crop_offset = (w2 != 0) ? ((xpad * w1) / w2) & 64'h3FF : 0;
    endfunction

    // True when the request produces a pixel from the store.
    function bit on_screen(longint unsigned row, longint unsigned col);
      return !(row >= regs[REG_DST_H] || col >= regs[REG_DST_W] || row >= SCREEN_ROWS ||
               col >= SCREEN_COLS);
    endfunction

    function longint unsigned top_left(longint unsigned row, longint unsigned col);
      longint unsigned stride;
      stride = regs[REG_STRIDE];
      return stride * regs[REG_ORIGIN_Y] + regs[REG_ORIGIN_X] +
             ((row * y_step) >> 16) * stride + crop_offset + ((col * x_step) >> 16);
    endfunction

    function logic [31:0] fetch(longint unsigned addr);
      longint unsigned a;
      a = addr & STORE_MASK;
      return store.exists(a) ? store[a] : 32'h0;
    endfunction

    function void note_item(opcode_e op, logic [FRAME_AW-1:0] addr, logic [31:0] data,
                            logic [7:0] row_in, logic [8:0] col_in);
      scaled_px_t      e;
      longint unsigned row, col, xpos, ypos, x, y, xd, yd, base, stride, cols, ypad, sum;
      longint unsigned wt [4];
      logic [31:0]     px [4];
      bit              right, down;
      if (op == OP_WRITE) begin
        store[addr] = data;
        return;
      end
      row = row_in;
      col = col_in;
      e = '{pixel: 32'h0, index: 16'h0, status: ST_OUTSIDE};
      if (row >= regs[REG_DST_H] || col >= regs[REG_DST_W] || row >= SCREEN_ROWS) begin
        pending_px.push_back(e);
        return;
      end
      if (col >= SCREEN_COLS) begin
        e.status = ST_CROPPED;
        pending_px.push_back(e);
        return;
      end
      stride = regs[REG_STRIDE];
      cols = (regs[REG_DST_W] > SCREEN_COLS) ? SCREEN_COLS : regs[REG_DST_W];
      ypad = (regs[REG_DST_H] < SCREEN_ROWS) ? (SCREEN_ROWS - regs[REG_DST_H]) / 2 : 0;
      xpos = col * x_step;
      ypos = row * y_step;
      x = xpos >> 16;
      y = ypos >> 16;
      xd = xpos & 64'hFFFF;
      yd = ypos & 64'hFFFF;
      base = top_left(row, col);
      px[0] = fetch(base);
      if (regs[REG_MODE] == MODE_NEAREST) begin
        e.pixel = px[0];
      end else begin
        right = (x + 1 < regs[REG_SRC_W]);
        down  = (y + 1 < regs[REG_SRC_H]);
        px[1] = right ? fetch(base + 1) : px[0];
        px[2] = down ? fetch(base + stride) : px[0];
        px[3] = (right && down) ? fetch(base + stride + 1) : px[0];
        // Weights are 1.24 fixed point; the corner product stays wide.
        wt[0] = ((65536 - xd) * (65536 - yd)) >> 8;
        wt[1] = (xd * (65536 - yd)) >> 8;
        wt[2] = (yd * (65536 - xd)) >> 8;
        wt[3] = (yd * xd) >> 8;
        for (int ch = 0; ch < 4; ch++) begin
          sum = 0;
          for (int k = 0; k < 4; k++)
            sum += ((longint'(px[k] >> (8 * ch)) & 64'hFF) * wt[k]) >> 24;
          e.pixel[8*ch +: 8] = sum[7:0];
        end
      end
      e.index  = 16'((row + ypad) * cols + col);
      e.status = ST_WRITTEN;
      pending_px.push_back(e);
    endfunction

    function void check(logic [31:0] pixel, logic [15:0] index, logic [1:0] status);
      scaled_px_t e;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result pixel=%h index=%0d status=%0d",
                   pixel, index, status);
        return;
      end
      e = pending_px.pop_front();
      if (pixel !== e.pixel || index !== e.index || status !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected pixel=%h index=%0d status=%0d, got pixel=%h index=%0d status=%0d",
                   e.pixel, e.index, e.status, pixel, index, status);
      end
    endfunction

    function int pending();
      return pending_px.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fpis_cfg_if cfg_if ();
  fpis_in_if  in_if ();
  fpis_out_if out_if ();

  fixed_point_image_scaler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  scaler_scoreboard sb = new();

  bit              steady;       // no gaps or stalls in this stretch
  bit              hold_off_req; // ask the receiver for one long hold-off
  bit              out_taken;
  int              out_stall;
  int              sent_items;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive every input to a known value before reset releases.
  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SRC_W;
    cfg_if.data  = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_WRITE;
    in_if.store_address = '0;
    in_if.store_pixel = '0;
    in_if.out_row = '0;
    in_if.out_col = '0;
    out_if.ready = 1'b0;
  end

  // Monitor: note accepted items, register writes and results at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.note_item(opcode_e'(in_if.opcode), in_if.store_address, in_if.store_pixel,
                     in_if.out_row, in_if.out_col);
      if (out_if.valid && out_if.ready) begin
        sb.check(out_if.out_pixel, out_if.dest_index, out_if.status);
        out_taken = 1'b1;
      end
    end
  end

  // Receiver: draw a stall per result, with one long hold-off when asked.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if (out_taken) begin
        out_taken = 1'b0;
        out_stall = steady ? 0 : $urandom_range(0, 12);
      end
      if (out_stall > 0) begin
        out_if.ready = 1'b0;
        out_stall--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(opcode_e op, logic [FRAME_AW-1:0] addr, logic [31:0] data,
                           logic [7:0] row, logic [8:0] col);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.opcode = op;
    in_if.store_address = addr;
    in_if.store_pixel = data;
    in_if.out_row = row;
    in_if.out_col = col;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
  endtask

  // Load any neighbor the request could touch, then issue the request.
  task automatic request_pixel(logic [7:0] row, logic [8:0] col);
    longint unsigned base, stride, a;
    longint unsigned offs [4];
    if (sb.on_screen(row, col)) begin
      base = sb.top_left(row, col);
      stride = sb.regs[REG_STRIDE];
      offs = '{0, 1, stride, stride + 1};
      foreach (offs[k]) begin
        a = (base + offs[k]) & STORE_MASK;
        if (!sb.store.exists(a))
          send_item(OP_WRITE, FRAME_AW'(a), $urandom, 8'($urandom), 9'($urandom));
      end
    end
    send_item(OP_REQUEST, FRAME_AW'($urandom), $urandom, row, col);
  endtask

  // Return to idle: drop valid, drain results, let the pipeline empty.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (FLUSH_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_setting(int w1, int h1, int stride, int ox, int oy, int w2, int h2,
                               mode_e mode);
    write_reg(REG_SRC_W, w1);
    write_reg(REG_SRC_H, h1);
    write_reg(REG_STRIDE, stride);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_DST_W, w2);
    write_reg(REG_DST_H, h2);
    write_reg(REG_MODE, mode);
  endtask

  // Mostly in-window requests, some anywhere, plus stray store writes;
  // runs until n input items have gone in, loads included.
  task automatic random_burst(int n);
    int unsigned w2, h2, roll;
    int          stop;
    w2 = sb.regs[REG_DST_W];
    h2 = sb.regs[REG_DST_H];
    stop = sent_items + n;
    while (sent_items < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_item(OP_WRITE, FRAME_AW'($urandom), $urandom, 8'($urandom), 9'($urandom));
      end else if (roll < 80 && w2 != 0 && h2 != 0) begin
        request_pixel($urandom_range(0, (h2 > SCREEN_ROWS ? SCREEN_ROWS : h2) - 1),
                      $urandom_range(0, w2 - 1));
      end else begin
        request_pixel(8'($urandom), 9'($urandom));
      end
    end
  endtask

  initial begin
    steady = 1'b0;
    hold_off_req = 1'b0;
    out_taken = 1'b0;
    sent_items = 0;
    cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state: steps are zero until a register is written.
    request_pixel(0, 0);
    request_pixel(239, 239);
    request_pixel(240, 0);
    settle();

    // Largest window, wide image cropped to the screen, bilinear.
    apply_setting(512, 512, 512, 0, 0, 512, 240, MODE_BILINEAR);
    request_pixel(0, 0);
    request_pixel(239, 239);
    request_pixel(0, 240);
    request_pixel(239, 511);
    request_pixel(255, 0);
    request_pixel(120, 17);
    settle();

    // Single pixel window at the far corner: every neighbor falls back.
    apply_setting(1, 1, 1, 511, 511, 1, 1, MODE_NEAREST);
    request_pixel(0, 0);
    request_pixel(0, 1);
    request_pixel(1, 0);
    settle();
    write_reg(REG_MODE, MODE_BILINEAR);
    request_pixel(0, 0);
    settle();

    // Tall image: vertical pad saturates.
    apply_setting(100, 300, 128, 3, 7, 240, 250, MODE_BILINEAR);
    request_pixel(239, 0);
    request_pixel(0, 239);
    request_pixel(245, 5);
    settle();

    // Zero destination size, and a write to an unmapped register.
    write_reg(REG_DST_W, 0);
    write_reg(REG_DST_H, 0);
    write_reg(REG_UNMAPPED, 10'h3FF);
    request_pixel(0, 0);
    request_pixel(255, 511);
    settle();

    // Random settings; one phase runs with a long receiver hold-off.
    for (int ph = 0; ph < 9; ph++) begin
      apply_setting($urandom_range(1, 512), $urandom_range(1, 512), $urandom_range(1, 512),
                    $urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom_range(1, 512), $urandom_range(1, 240),
                    mode_e'($urandom_range(0, 1)));
      steady = (ph % 3 == 1);
      if (ph == 2) hold_off_req = 1'b1;
      random_burst(REQ_ITEMS / 9);
      steady = 1'b0;
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
